// ===== src/htkv_pkg.sv =====
// Shared definitions for the hashed tree key/value map unit.
// Field widths, default sizes, status codes, controller states and the
// command and status structs used between the controller and the datapath.
`default_nettype none

package htkv_pkg;

    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int ACTION_W = 2;
    localparam int DEPTH_W  = 10;
    localparam int DEPTH_MAX = 1023;

    localparam int NODE_COUNT_DEF  = 1024;
    localparam int ROOT_COUNT_DEF  = 256;
    localparam int CHILD_COUNT_DEF = 4;

    localparam logic [ACTION_W-1:0] ACT_ADD = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SET = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_DIFFER  = 2'd1,
        STATUS_FULL    = 2'd2,
        STATUS_REFUSED = 2'd3
    } status_code_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SLOT,
        S_ROOT,
        S_NREAD,
        S_NCMP,
        S_BRANCH,
        S_DECIDE,
        S_LINK,
        S_RESP
    } state_t;

    typedef struct packed {
        logic         load;
        logic         slot_start;
        logic         root_read;
        logic         root_take;
        logic         node_read;
        logic         take_found;
        logic         branch_start;
        logic         branch_take;
        logic         note_depth;
        logic         value_write;
        logic         alloc;
        logic         set_fail;
        logic         res_status_we;
        status_code_t res_status;
        logic         link;
        logic         out_load;
    } cmd_t;

    typedef struct packed {
        logic failed;
        logic slot_done;
        logic root_zero;
        logic diff_zero;
        logic br_done;
        logic child_zero;
        logic found;
        logic act_add;
        logic act_set;
        logic value_differs;
        logic pool_full;
        logic parent_zero;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== src/hashed_tree_key_value_map_unit.sv =====
// Top level of the hashed tree key/value map unit.
// Joins the controller (htkv_ctrl) and the datapath (htkv_dpath); uses htkv_pkg.
//
//  Channel | Role   | tdata (low bit up)                        | tuser (low bit up)
//  s_*     | input  | key[31:0], new_value[63:32]               | action[1:0]
//  m_*     | output | stored_value[31:0], max_depth[41:32], pad | status[1:0], found[2]
//
// A request passes through acceptance, the slot hash, a root table read, a read and a compare
// per node visited plus the branch hash when the walk goes on, an update step, a link step
// when a new node is placed below a parent, and the response; a refused one goes straight
// from acceptance to the response.
// Reset clears the root valid bits at once; no clearing pass is needed. A result waits in
// the output register while the next request runs; a finished one waits for it to empty.
`default_nettype none

module hashed_tree_key_value_map_unit #(
    parameter int NODE_COUNT  = htkv_pkg::NODE_COUNT_DEF,
    parameter int ROOT_COUNT  = htkv_pkg::ROOT_COUNT_DEF,
    parameter int CHILD_COUNT = htkv_pkg::CHILD_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // key[31:0], new_value[63:32]
    input  wire logic [1:0]  s_tuser,   // action[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // stored_value[31:0], max_depth[41:32], zeros
    output logic [2:0]       m_tuser    // status[1:0], found[2]
);
    import htkv_pkg::*;

    cmd_t                cmd;
    stat_t               stat;
    status_code_t        out_status;
    logic                out_found;
    logic [VALUE_W-1:0]  out_stored;
    logic [DEPTH_W-1:0]  out_depth;

    htkv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    htkv_dpath #(
        .NODE_COUNT  (NODE_COUNT),
        .ROOT_COUNT  (ROOT_COUNT),
        .CHILD_COUNT (CHILD_COUNT)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_action  (s_tuser),
        .in_key     (s_tdata[KEY_W-1:0]),
        .in_value   (s_tdata[KEY_W+VALUE_W-1:KEY_W]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (out_status),
        .out_found  (out_found),
        .out_stored (out_stored),
        .out_depth  (out_depth)
    );

    assign m_tdata = {6'b0, out_depth, out_stored};
    assign m_tuser = {out_found, out_status};

endmodule

`default_nettype wire

// ===== src/htkv_mod.sv =====
// Remainder of a 32-bit unsigned operand by a constant divisor.
// A power-of-two divisor is a mask with a registered result; any other divisor
// folds one operand byte a cycle through two constant residue tables. Uses htkv_pkg.
`default_nettype none

module htkv_mod #(
    parameter int DIVISOR = 4
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [htkv_pkg::KEY_W-1:0]      operand,
    output logic                                 done,
    output logic [$clog2(DIVISOR)-1:0]           result
);
    import htkv_pkg::*;

    localparam int RES_W = $clog2(DIVISOR);

    logic done_reg;

    assign done = done_reg;

    generate
        if ((DIVISOR & (DIVISOR - 1)) == 0) begin : g_mask
            logic [RES_W-1:0] res_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    res_reg <= operand[RES_W-1:0];
                end
            end

            assign result = res_reg;
        end
        else begin : g_iter
            localparam int REM_W     = RES_W + 1;
            localparam int STEP_BITS = 8;
            localparam int STEPS     = KEY_W / STEP_BITS;
            localparam int CNT_W     = $clog2(STEPS + 1);
            localparam int HI_N      = 2 ** RES_W;

            logic [RES_W-1:0] rem_reg;
            logic [RES_W-1:0] rem_next;
            logic [REM_W-1:0] fold_sum;
            logic [KEY_W-1:0] shift_reg;
            logic [CNT_W-1:0] cnt_reg;
            logic             busy_reg;
            logic [RES_W-1:0] byte_tab [256];
            logic [RES_W-1:0] hi_tab [HI_N];

            // The residue of a byte, and the residue of a partial remainder
            // shifted up by one byte.
            for (genvar g = 0; g < 256; g++) begin : g_byte_tab
                assign byte_tab[g] = RES_W'(g % DIVISOR);
            end
            for (genvar g = 0; g < HI_N; g++) begin : g_hi_tab
                assign hi_tab[g] = RES_W'((g * 256) % DIVISOR);
            end

            // Both residues stay below the divisor, so one compare and
            // subtract brings their sum back into range.
            assign fold_sum = {1'b0, hi_tab[rem_reg]}
                            + {1'b0, byte_tab[shift_reg[KEY_W-1 -: STEP_BITS]]};
            assign rem_next = (fold_sum >= REM_W'(DIVISOR))
                            ? RES_W'(fold_sum - REM_W'(DIVISOR))
                            : fold_sum[RES_W-1:0];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        busy_reg <= 1'b1;
                        cnt_reg  <= CNT_W'(STEPS);
                    end
                    else if (busy_reg)
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                        if (cnt_reg == CNT_W'(1))
                        begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg   <= '0;
                    shift_reg <= operand;
                end
                else if (busy_reg)
                begin
                    rem_reg   <= rem_next;
                    shift_reg <= shift_reg << STEP_BITS;
                end
            end

            assign result = rem_reg;
        end
    endgenerate

endmodule

`default_nettype wire

// ===== src/htkv_ctrl.sv =====
// Controller state machine of the hashed tree key/value map unit.
// Sequences hashing, the tree walk, the update and the response; drives the
// datapath through htkv_pkg::cmd_t and reads htkv_pkg::stat_t.
`default_nettype none

module htkv_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output htkv_pkg::cmd_t       cmd,
    input  wire htkv_pkg::stat_t stat
);
    import htkv_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = stat.failed ? S_RESP : S_SLOT;
                end
            end
            S_SLOT:
            begin
                if (stat.slot_done)
                begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT:   state_next = stat.root_zero ? S_DECIDE : S_NREAD;
            S_NREAD:  state_next = S_NCMP;
            S_NCMP:   state_next = stat.diff_zero ? S_DECIDE : S_BRANCH;
            S_BRANCH:
            begin
                if (stat.br_done)
                begin
                    state_next = stat.child_zero ? S_DECIDE : S_NREAD;
                end
            end
            S_DECIDE:
            begin
                state_next = S_RESP;
                if (!stat.found && (stat.act_add || stat.act_set) && !stat.pool_full
                    && !stat.parent_zero)
                begin
                    state_next = S_LINK;
                end
            end
            S_LINK:   state_next = S_RESP;
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready       = 1'b1;
                cmd.load       = s_tvalid;
                cmd.slot_start = s_tvalid && !stat.failed;
            end
            S_SLOT:   cmd.root_read = stat.slot_done;
            S_ROOT:   cmd.root_take = 1'b1;
            S_NREAD:  cmd.node_read = 1'b1;
            S_NCMP:
            begin
                cmd.take_found   = stat.diff_zero;
                cmd.branch_start = !stat.diff_zero;
            end
            S_BRANCH: cmd.branch_take = stat.br_done;
            S_DECIDE:
            begin
                cmd.note_depth = 1'b1;
                if (stat.found)
                begin
                    cmd.value_write = stat.act_set;
                    if (stat.act_add && stat.value_differs)
                    begin
                        cmd.res_status_we = 1'b1;
                        cmd.res_status    = STATUS_DIFFER;
                    end
                end
                else if (stat.act_add || stat.act_set)
                begin
                    if (stat.pool_full)
                    begin
                        cmd.set_fail      = 1'b1;
                        cmd.res_status_we = 1'b1;
                        cmd.res_status    = STATUS_FULL;
                    end
                    else
                    begin
                        cmd.alloc = 1'b1;
                    end
                end
            end
            S_LINK:   cmd.link = 1'b1;
            S_RESP:   cmd.out_load = stat.out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/htkv_dpath.sv =====
// Datapath of the hashed tree key/value map unit: root table, node pool
// memories, walk registers, counters and the output register.
// Depends on htkv_pkg and htkv_mod; driven by htkv_ctrl commands.
`default_nettype none

module htkv_dpath #(
    parameter int NODE_COUNT  = htkv_pkg::NODE_COUNT_DEF,
    parameter int ROOT_COUNT  = htkv_pkg::ROOT_COUNT_DEF,
    parameter int CHILD_COUNT = htkv_pkg::CHILD_COUNT_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire htkv_pkg::cmd_t                    cmd,
    output htkv_pkg::stat_t                        stat,
    input  wire logic [htkv_pkg::ACTION_W-1:0]     in_action,
    input  wire logic [htkv_pkg::KEY_W-1:0]        in_key,
    input  wire logic [htkv_pkg::VALUE_W-1:0]      in_value,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output htkv_pkg::status_code_t                 out_status,
    output logic                                   out_found,
    output logic [htkv_pkg::VALUE_W-1:0]           out_stored,
    output logic [htkv_pkg::DEPTH_W-1:0]           out_depth
);
    import htkv_pkg::*;

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int SLOT_W = $clog2(ROOT_COUNT);
    localparam int BR_W   = $clog2(CHILD_COUNT);
    localparam int LEV_W  = $clog2(NODE_COUNT);
    localparam int CMP_W  = (LEV_W > DEPTH_W) ? LEV_W : DEPTH_W;

    // Request registers.
    logic [ACTION_W-1:0] action_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [VALUE_W-1:0]  nval_reg;

    // Walk registers.
    logic [IDX_W-1:0]    cur_reg;
    logic [IDX_W-1:0]    parent_reg;
    logic [IDX_W-1:0]    fresh_reg;
    logic [LEV_W-1:0]    lev_reg;

    // Persistent control state.
    logic [IDX_W:0]      next_free_reg;
    logic                failed_reg;
    logic [DEPTH_W-1:0]  deepest_reg;

    // Result under construction.
    logic                found_reg;
    logic [VALUE_W-1:0]  stored_reg;
    status_code_t        res_status_reg;

    // Output register.
    logic                out_valid_reg;
    status_code_t        out_status_reg;
    logic                out_found_reg;
    logic [VALUE_W-1:0]  out_stored_reg;
    logic [DEPTH_W-1:0]  out_depth_reg;

    // Memories.
    logic [IDX_W-1:0]    root_mem [ROOT_COUNT];
    logic [ROOT_COUNT-1:0] root_valid_reg;
    logic [IDX_W-1:0]    root_rd_reg;
    logic                root_rd_valid_reg;
    logic [KEY_W-1:0]    key_mem [NODE_COUNT];
    logic [VALUE_W-1:0]  val_mem [NODE_COUNT];
    logic [KEY_W-1:0]    key_rd_reg;
    logic [VALUE_W-1:0]  val_rd_reg;
    logic [IDX_W-1:0]    child_rd [CHILD_COUNT];

    // Hashing units.
    logic                slot_done;
    logic [SLOT_W-1:0]   slot_res;
    logic                br_done;
    logic [BR_W-1:0]     br_res;
    logic [KEY_W-1:0]    diff;

    logic [IDX_W-1:0]    root_node;
    logic [IDX_W-1:0]    fresh;
    logic [CMP_W-1:0]    lev_ext;
    logic [DEPTH_W-1:0]  lev_sat;
    logic [IDX_W-1:0]    val_waddr;

    assign diff      = key_reg - key_rd_reg;
    assign root_node = root_rd_valid_reg ? root_rd_reg : '0;
    assign fresh     = next_free_reg[IDX_W-1:0];
    assign lev_ext   = CMP_W'(lev_reg);
    assign lev_sat   = (lev_ext > CMP_W'(DEPTH_MAX)) ? DEPTH_W'(DEPTH_MAX)
                                                     : lev_ext[DEPTH_W-1:0];
    assign val_waddr = cmd.alloc ? fresh : cur_reg;

    htkv_mod #(
        .DIVISOR (ROOT_COUNT)
    ) u_slot_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.slot_start),
        .operand (in_key),
        .done    (slot_done),
        .result  (slot_res)
    );

    htkv_mod #(
        .DIVISOR (CHILD_COUNT)
    ) u_branch_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.branch_start),
        .operand (diff),
        .done    (br_done),
        .result  (br_res)
    );

    always_comb
    begin
        stat.failed        = failed_reg;
        stat.slot_done     = slot_done;
        stat.root_zero     = (root_node == '0);
        stat.diff_zero     = (diff == '0);
        stat.br_done       = br_done;
        stat.child_zero    = (child_rd[br_res] == '0);
        stat.found         = found_reg;
        stat.act_add       = (action_reg == ACT_ADD);
        stat.act_set       = (action_reg == ACT_SET);
        stat.value_differs = (stored_reg != nval_reg);
        stat.pool_full     = (next_free_reg >= (IDX_W+1)'(NODE_COUNT));
        stat.parent_zero   = (parent_reg == '0);
        stat.out_free      = !out_valid_reg || out_ready;
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_free_reg  <= (IDX_W+1)'(1);
            failed_reg     <= 1'b0;
            deepest_reg    <= '0;
            root_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.alloc)
            begin
                next_free_reg <= next_free_reg + 1'b1;
                if (parent_reg == '0)
                begin
                    root_valid_reg[slot_res] <= 1'b1;
                end
            end
            if (cmd.set_fail)
            begin
                failed_reg <= 1'b1;
            end
            if (cmd.note_depth && (lev_sat > deepest_reg))
            begin
                deepest_reg <= lev_sat;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg     <= in_action;
            key_reg        <= in_key;
            nval_reg       <= in_value;
            found_reg      <= 1'b0;
            stored_reg     <= '0;
            res_status_reg <= failed_reg ? STATUS_REFUSED : STATUS_OK;
        end
        if (cmd.root_take)
        begin
            cur_reg    <= root_node;
            parent_reg <= '0;
            lev_reg    <= '0;
        end
        if (cmd.take_found)
        begin
            found_reg  <= 1'b1;
            stored_reg <= val_rd_reg;
        end
        if (cmd.branch_start)
        begin
            parent_reg <= cur_reg;
            lev_reg    <= lev_reg + 1'b1;
        end
        if (cmd.branch_take)
        begin
            cur_reg <= child_rd[br_res];
        end
        if (cmd.alloc)
        begin
            fresh_reg <= fresh;
        end
        if (cmd.res_status_we)
        begin
            res_status_reg <= cmd.res_status;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= found_reg;
            out_stored_reg <= stored_reg;
            out_depth_reg  <= deepest_reg;
        end
    end

    // Root table: an empty slot is one whose valid bit is clear.
    always_ff @(posedge clk)
    begin
        if (cmd.root_read)
        begin
            root_rd_reg       <= root_mem[slot_res];
            root_rd_valid_reg <= root_valid_reg[slot_res];
        end
        if (cmd.alloc && (parent_reg == '0))
        begin
            root_mem[slot_res] <= fresh;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.node_read)
        begin
            key_rd_reg <= key_mem[cur_reg];
            val_rd_reg <= val_mem[cur_reg];
        end
        if (cmd.alloc)
        begin
            key_mem[fresh] <= key_reg;
        end
        if (cmd.alloc || cmd.value_write)
        begin
            val_mem[val_waddr] <= nval_reg;
        end
    end

    // One memory per branch lane: a new node clears all its lanes, and the
    // link to it is written into one lane of the parent in the following cycle.
    generate
        for (genvar lane = 0; lane < CHILD_COUNT; lane++) begin : g_lane
            logic [IDX_W-1:0] child_mem [NODE_COUNT];
            logic             lane_we;
            logic [IDX_W-1:0] lane_addr;
            logic [IDX_W-1:0] lane_data;

            assign lane_we   = cmd.alloc || (cmd.link && (br_res == BR_W'(lane)));
            assign lane_addr = cmd.alloc ? fresh : parent_reg;
            assign lane_data = cmd.alloc ? '0 : fresh_reg;

            always_ff @(posedge clk)
            begin
                if (cmd.node_read)
                begin
                    child_rd[lane] <= child_mem[cur_reg];
                end
                if (lane_we)
                begin
                    child_mem[lane_addr] <= lane_data;
                end
            end
        end
    endgenerate

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_found  = out_found_reg;
    assign out_stored = out_stored_reg;
    assign out_depth  = out_depth_reg;

    a_alloc_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc |-> (next_free_reg < (IDX_W+1)'(NODE_COUNT)))
        else $error("node allocated from a full pool");

    a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |=> failed_reg)
        else $error("failure flag cleared");

    a_depth_grows: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (deepest_reg >= $past(deepest_reg)))
        else $error("deepest walk decreased");

    a_link_parent: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.link |-> ((parent_reg != '0) && $past(cmd.alloc)))
        else $error("child link without a parent node or fresh allocation");

endmodule

`default_nettype wire

// ===== tb/sv/tb_hashed_tree_key_value_map_unit.sv =====
// Self-checking testbench for the hashed tree key/value map unit.
// A scoreboard class mirrors the root table, node pool and sticky failure and
// checks every response; depends on htkv_pkg and hashed_tree_key_value_map_unit.
`default_nettype none

module tb_hashed_tree_key_value_map_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import htkv_pkg::*;

    localparam int NODES     = NODE_COUNT_DEF;
    localparam int ROOTS     = ROOT_COUNT_DEF;
    localparam int BRANCHES  = CHILD_COUNT_DEF;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 340;
    localparam int LAST_ITEMS   = 40;

    localparam logic [ACTION_W-1:0] ACT_FIND  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

    typedef struct {
        status_code_t         status;
        bit                   found;
        bit [VALUE_W-1:0]     stored;
        bit [DEPTH_W-1:0]     depth;
    } map_response_t;

    class map_scoreboard;
        int unsigned         root_head [ROOTS];
        bit [KEY_W-1:0]      key_store [NODES];
        bit [VALUE_W-1:0]    value_store [NODES];
        int unsigned         child_link [NODES*BRANCHES];
        int unsigned         free_index;
        bit                  pool_failed;
        bit [DEPTH_W-1:0]    deepest;
        map_response_t       awaited [$];
        int unsigned         mismatches;

        function new();
            foreach (root_head[i]) root_head[i] = 0;
            free_index  = 1;
            pool_failed = 1'b0;
            deepest     = '0;
            mismatches  = 0;
        endfunction

        // Walks the tree exactly as the block does and queues the response.
        function void note_request(bit [ACTION_W-1:0] action, bit [KEY_W-1:0] key,
                                   bit [VALUE_W-1:0] value);
            map_response_t  r;
            int unsigned    slot, node, parent, branch, lev, fresh;
            bit [KEY_W-1:0] diff;
            bit             hit;
            r.status = STATUS_OK;
            r.found  = 1'b0;
            r.stored = '0;
            if (pool_failed) begin
                r.status = STATUS_REFUSED;
            end else begin
                slot   = key % ROOTS;
                node   = root_head[slot];
                parent = 0;
                branch = 0;
                lev    = 0;
                hit    = 1'b0;
                while (!hit && node != 0 && node < NODES && lev <= NODES) begin
                    diff = key - key_store[node];
                    if (diff == 0) begin
                        hit = 1'b1;
                    end else begin
                        parent = node;
                        branch = diff % BRANCHES;
                        node   = child_link[node*BRANCHES + branch];
                        lev++;
                    end
                end
                if (lev > DEPTH_MAX) lev = DEPTH_MAX;
                if (lev > deepest) deepest = lev[DEPTH_W-1:0];
                if (hit) begin
                    r.found  = 1'b1;
                    r.stored = value_store[node];
                    if (action == ACT_ADD) begin
                        if (r.stored != value) r.status = STATUS_DIFFER;
                    end else if (action == ACT_SET) begin
                        value_store[node] = value;
                    end
                end else if (action == ACT_ADD || action == ACT_SET) begin
                    if (free_index >= NODES) begin
                        pool_failed = 1'b1;
                        r.status    = STATUS_FULL;
                    end else begin
                        fresh = free_index;
                        free_index++;
                        key_store[fresh]   = key;
                        value_store[fresh] = value;
                        for (int c = 0; c < BRANCHES; c++) child_link[fresh*BRANCHES + c] = 0;
                        if (parent == 0) root_head[slot] = fresh;
                        else child_link[parent*BRANCHES + branch] = fresh;
                    end
                end
            end
            r.depth = deepest;
            awaited.push_back(r);
        endfunction

        function void check_response(logic [1:0] status, logic found,
                                     logic [VALUE_W-1:0] stored, logic [DEPTH_W-1:0] depth);
            map_response_t e;
            if (awaited.size() == 0) begin
                if (mismatches < 10)
                    $display("response with nothing awaited: status %0d found %0d stored %h",
                             status, found, stored);
                mismatches++;
                return;
            end
            e = awaited.pop_front();
            if (status !== e.status || found !== e.found || stored !== e.stored ||
                depth !== e.depth) begin
                if (mismatches < 10)
                    $display("mismatch: exp %0d %0d %h %0d, got %0d %0d %h %0d",
                             e.status, e.found, e.stored, e.depth,
                             status, found, stored, depth);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [63:0]       s_tdata;
    logic [1:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [47:0]       m_tdata;
    logic [2:0]        m_tuser;

    map_scoreboard     sb;
    int unsigned       send_odds;
    int unsigned       recv_odds;
    bit                hold_req;
    int unsigned       cycle_count;
    bit [KEY_W-1:0]    working_keys [64];
    bit [7:0]          hot_slots [6];
    bit [VALUE_W-1:0]  value_pool [4];

    hashed_tree_key_value_map_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** hashed_tree_key_value_map_unit: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_response(m_tuser[1:0], m_tuser[2], m_tdata[31:0], m_tdata[41:32]);
    end

    // Receiver: random back-pressure bursts, plus one long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end else if (recv_odds != 0 && $urandom_range(1, recv_odds) == 1) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge clk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    task automatic send_request(bit [ACTION_W-1:0] action, bit [KEY_W-1:0] key,
                                bit [VALUE_W-1:0] value);
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = action;
        s_tdata  = {value, key};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_request(action, key, value);
    endtask

    task automatic sender_gap();
        int unsigned n;
        if (send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
            n = $urandom_range(1, 19);
            @(negedge clk);
            s_tvalid = 1'b0;
            s_tdata  = {$urandom, $urandom};
            s_tuser  = 2'($urandom_range(0, 3));
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
    endtask

    function automatic bit [KEY_W-1:0] pick_key();
        bit [KEY_W-1:0] k;
        int unsigned    r;
        r = $urandom_range(0, 9);
        k = $urandom;
        if (r <= 5) k = working_keys[$urandom_range(0, 63)];
        else if (r <= 7) k[7:0] = hot_slots[$urandom_range(0, 5)];
        return k;
    endfunction

    function automatic bit [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 9) <= 5) return value_pool[$urandom_range(0, 3)];
        return $urandom;
    endfunction

    function automatic bit [ACTION_W-1:0] pick_action();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r <= 2) return ACT_FIND;
        if (r <= 5) return ACT_ADD;
        if (r <= 8) return ACT_SET;
        return ACT_SPARE;
    endfunction

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        hold_req    = 1'b0;
        cycle_count = 0;
        send_odds   = 4;
        recv_odds   = 4;
        value_pool  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        foreach (hot_slots[i]) hot_slots[i] = 8'($urandom);
        foreach (working_keys[i]) begin
            working_keys[i] = $urandom;
            if (i % 2 == 0) working_keys[i][7:0] = hot_slots[$urandom_range(0, 5)];
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: empty finds, the spare action, equal and different adds,
        // overwrites, extreme keys and values, and chains sharing one root slot.
        send_request(ACT_FIND,  32'h0000_0000, 32'hFFFF_FFFF);
        send_request(ACT_SPARE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(ACT_ADD,   32'h0000_0000, 32'h7FFF_FFFF);
        sender_gap();
        send_request(ACT_ADD,   32'h0000_0000, 32'h7FFF_FFFF);
        send_request(ACT_ADD,   32'h0000_0000, 32'h8000_0000);
        send_request(ACT_SET,   32'h0000_0000, 32'h8000_0000);
        send_request(ACT_FIND,  32'h0000_0000, 32'h0000_0000);
        sender_gap();
        send_request(ACT_SPARE, 32'h0000_0000, 32'h1234_5678);
        send_request(ACT_SET,   32'h8000_0000, 32'h0000_0000);
        send_request(ACT_ADD,   32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(ACT_ADD,   32'hFFFF_FFFF, 32'h1234_5678);
        sender_gap();
        send_request(ACT_SET,   32'h7FFF_FFFF, 32'h0000_0000);
        send_request(ACT_FIND,  32'hFFFF_FFFF, 32'h0000_0000);
        send_request(ACT_ADD,   32'h0000_0100, 32'h0000_0001);
        send_request(ACT_FIND,  32'h0000_0200, 32'h0000_0000);
        send_request(ACT_ADD,   32'h5555_5555, 32'hAAAA_AAAA);
        send_request(ACT_ADD,   32'hAAAA_AAAA, 32'h5555_5555);
        send_request(ACT_FIND,  32'hAAAA_AAAA, 32'h0000_0000);
        send_request(ACT_SPARE, 32'h5555_5555, 32'hFFFF_FFFF);
        drain();

        // Random part, mostly on a working set of keys so that hits are common.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 100) begin
                send_odds = 0;
                recv_odds = 0;
            end
            if (i == 150) begin
                send_odds = 3;
                recv_odds = 3;
                hold_req  = 1'b1;
            end
            if (i == 250) begin
                drain();
                send_odds = 2;
                recv_odds = 6;
            end
            sender_gap();
            send_request(pick_action(), pick_key(), pick_value());
        end
        drain();

        // Last part with no idling on either side.
        send_odds = 0;
        recv_odds = 0;
        for (int i = 0; i < LAST_ITEMS; i++)
            send_request(pick_action(), pick_key(), pick_value());

        drain();
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("** hashed_tree_key_value_map_unit: PASSED **");
        else
            $display("** hashed_tree_key_value_map_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
src/htkv_pkg.sv
src/htkv_mod.sv
src/htkv_ctrl.sv
src/htkv_dpath.sv
src/hashed_tree_key_value_map_unit.sv
tb/sv/tb_hashed_tree_key_value_map_unit.sv
